FILE: rtl/core/mpt_pkg.sv
// Shared types and constants for the mouse pointer tracker.
// No dependencies; the files that use it refer to it by scoped names.
package mpt_pkg;

  // Input command codes
  localparam logic CMD_BYTE     = 1'b0;
  localparam logic CMD_RECENTER = 1'b1;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic REG_MAX_X      = 1'b0;
  localparam logic REG_MAX_Y      = 1'b1;
  localparam int   CFG_ADDR_WIDTH = 3;
  localparam int   CFG_DATA_WIDTH = 32;

  // Packet layout
  localparam int START_BIT  = 3;
  localparam int X_SIGN_BIT = 4;
  localparam int Y_SIGN_BIT = 5;

  // Byte slot of the open packet
  localparam logic [1:0] IDX_FIRST  = 2'd0;
  localparam logic [1:0] IDX_SECOND = 2'd1;
  localparam logic [1:0] IDX_THIRD  = 2'd2;

  typedef struct packed {
    logic moved;
    logic clipped;
  } upd_flags_t;

endpackage

FILE: rtl/core/mpt_stream_if.sv
// Valid/ready channel interfaces for the mouse pointer tracker.
// Input channel carries command and data byte; result channel carries pointer state.
interface mpt_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface mpt_out_if #(
  parameter int COORD_WIDTH = 12
);
  logic                          valid;
  logic                          ready;
  logic [COORD_WIDTH-1:0]        pos_x;
  logic [COORD_WIDTH-1:0]        pos_y;
  logic [2:0]                    buttons;
  logic                          moved;
  logic                          clipped;
  logic signed [COORD_WIDTH:0]   step_x;
  logic signed [COORD_WIDTH:0]   step_y;

  modport source (output valid, output pos_x, output pos_y, output buttons, output moved,
                  output clipped, output step_x, output step_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input buttons, input moved,
                  input clipped, input step_x, input step_y, output ready);
endinterface

FILE: rtl/core/mpt_cfg.sv
// APB-style register file holding the screen width and height limits.
// Depends on mpt_pkg for register indexes and port widths.
module mpt_cfg #(
  parameter int COORD_WIDTH = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mpt_pkg::CFG_ADDR_WIDTH-1:0]   paddr,
  input  logic [mpt_pkg::CFG_DATA_WIDTH-1:0]   pwdata,
  output logic [mpt_pkg::CFG_DATA_WIDTH-1:0]   prdata,
  output logic                                 pready,
  output logic [COORD_WIDTH-1:0]               max_x,
  output logic [COORD_WIDTH-1:0]               max_y
);

  localparam logic [COORD_WIDTH-1:0] WIDTH_RST  = COORD_WIDTH'(640);
  localparam logic [COORD_WIDTH-1:0] HEIGHT_RST = COORD_WIDTH'(480);

  logic [COORD_WIDTH-1:0] width_r, width_nxt;
  logic [COORD_WIDTH-1:0] height_r, height_nxt;
  logic                   wr_en;
  logic                   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      case (reg_idx)
        mpt_pkg::REG_MAX_X: width_nxt  = pwdata[COORD_WIDTH-1:0];
        mpt_pkg::REG_MAX_Y: height_nxt = pwdata[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mpt_pkg::REG_MAX_X:
        prdata = mpt_pkg::CFG_DATA_WIDTH'(width_r);
      mpt_pkg::REG_MAX_Y:
        prdata = mpt_pkg::CFG_DATA_WIDTH'(height_r);
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign max_x = width_r;
  assign max_y = height_r;

endmodule

FILE: rtl/core/mpt_update.sv
// Packet math: decode deltas, apply acceleration, move and clamp the pointer.
// Pure combinational; depends on mpt_pkg for packet bit positions and flag type.
module mpt_update #(
  parameter int COORD_WIDTH = 12
) (
  input  logic [7:0]                   byte0,
  input  logic [7:0]                   byte1,
  input  logic [7:0]                   byte2,
  input  logic [COORD_WIDTH-1:0]       cur_x,
  input  logic [COORD_WIDTH-1:0]       cur_y,
  input  logic [COORD_WIDTH-1:0]       lim_x,
  input  logic [COORD_WIDTH-1:0]       lim_y,
  output logic [COORD_WIDTH-1:0]       new_x,
  output logic [COORD_WIDTH-1:0]       new_y,
  output logic signed [COORD_WIDTH:0]  step_x,
  output logic signed [COORD_WIDTH:0]  step_y,
  output mpt_pkg::upd_flags_t          flags
);

  // Doubled deltas reach +-512, so sums need room for that beyond the coordinate
  localparam int SW = ((COORD_WIDTH > 11) ? COORD_WIDTH : 11) + 2;

  logic signed [8:0]    dx;
  logic signed [8:0]    dy_raw;
  logic signed [9:0]    dy;
  logic                 accel;
  logic signed [SW-1:0] dx_a;
  logic signed [SW-1:0] dy_a;
  logic signed [SW-1:0] sum_x;
  logic signed [SW-1:0] sum_y;
  logic signed [SW-1:0] lim_x_s;
  logic signed [SW-1:0] lim_y_s;
  logic                 clip_x;
  logic                 clip_y;

  assign dx     = $signed({byte0[mpt_pkg::X_SIGN_BIT], byte1});
  assign dy_raw = $signed({byte0[mpt_pkg::Y_SIGN_BIT], byte2});
  // Negate so positive Y points down the screen
  assign dy     = -$signed({dy_raw[8], dy_raw});

  // dx^2 + dy^2 >= 4 holds exactly when either magnitude is at least 2
  assign accel = (dx > 9'sd1) || (dx < -9'sd1) || (dy > 10'sd1) || (dy < -10'sd1);

  assign dx_a = accel ? (SW'(dx) <<< 1) : SW'(dx);
  assign dy_a = accel ? (SW'(dy) <<< 1) : SW'(dy);

  assign sum_x   = $signed({{(SW-COORD_WIDTH){1'b0}}, cur_x}) + dx_a;
  assign sum_y   = $signed({{(SW-COORD_WIDTH){1'b0}}, cur_y}) + dy_a;
  assign lim_x_s = $signed({{(SW-COORD_WIDTH){1'b0}}, lim_x});
  assign lim_y_s = $signed({{(SW-COORD_WIDTH){1'b0}}, lim_y});

  always_comb begin
    clip_x = 1'b0;
    new_x  = sum_x[COORD_WIDTH-1:0];
    if (sum_x < 0) begin
      clip_x = 1'b1;
      new_x  = '0;
    end else if (sum_x > lim_x_s) begin
      clip_x = 1'b1;
      new_x  = lim_x;
    end
  end

  always_comb begin
    clip_y = 1'b0;
    new_y  = sum_y[COORD_WIDTH-1:0];
    if (sum_y < 0) begin
      clip_y = 1'b1;
      new_y  = '0;
    end else if (sum_y > lim_y_s) begin
      clip_y = 1'b1;
      new_y  = lim_y;
    end
  end

  assign step_x = $signed({1'b0, new_x} - {1'b0, cur_x});
  assign step_y = $signed({1'b0, new_y} - {1'b0, cur_y});

  assign flags.moved   = (dx != 9'sd0) || (dy != 10'sd0);
  assign flags.clipped = clip_x || clip_y;

endmodule

FILE: rtl/core/mouse_pointer_tracker.sv
// Mouse pointer tracker top level: input register, packet state, result register.
// Depends on mpt_pkg, mpt_stream_if, mpt_cfg and mpt_update.
//
// Usage:
//   in_if  : one transfer per mouse byte (command = byte) or recenter request
//            (command = recenter). Bytes with bit 3 clear are dropped while no
//            packet is open; every third byte of a packet yields one result.
//   out_if : one transfer per completed packet with position, buttons, moved,
//            clipped and the actual step taken on each axis.
//   APB    : register 0 (address 0) screen width, register 1 (address 4)
//            screen height; write only while no transfer is in flight.
// Result path: the third byte's transfer loads the input register, and the
//   result register loads from the state update once that byte is processed.
// Throughput: one input transfer per cycle while out_if does not stall, set by
//   the combinational state update between the input and result registers.
// Reset: synchronous, active low; clears the packet slot count, the pointer
//   to (0, 0), both valid flags, and loads width 640 and height 480.
// Stall: with a result waiting and out_if.ready low, the result register holds
//   as does a loaded input register, so in_if.ready is low until the result goes.
module mouse_pointer_tracker #(
  parameter int COORD_WIDTH = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  mpt_in_if.sink                              in_if,
  mpt_out_if.source                           out_if,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mpt_pkg::CFG_ADDR_WIDTH-1:0]  paddr,
  input  logic [mpt_pkg::CFG_DATA_WIDTH-1:0]  pwdata,
  output logic [mpt_pkg::CFG_DATA_WIDTH-1:0]  prdata,
  output logic                                pready
);

  logic [COORD_WIDTH-1:0] scr_w;
  logic [COORD_WIDTH-1:0] scr_h;

  // Input register
  logic       in_valid_r, in_valid_nxt;
  logic       in_cmd_r;
  logic [7:0] in_byte_r;

  // Packet and pointer state
  logic [1:0]             byte_idx_r, byte_idx_nxt;
  logic [7:0]             held0_r, held1_r;
  logic [COORD_WIDTH-1:0] cursor_x_r, cursor_x_nxt;
  logic [COORD_WIDTH-1:0] cursor_y_r, cursor_y_nxt;

  // Result register
  logic                       out_valid_r, out_valid_nxt;
  logic [COORD_WIDTH-1:0]     res_x_r, res_y_r;
  logic [2:0]                 res_btn_r;
  mpt_pkg::upd_flags_t        res_flags_r;
  logic signed [COORD_WIDTH:0] res_step_x_r, res_step_y_r;

  logic                       advance;
  logic                       proc;
  logic                       finish;
  logic [COORD_WIDTH-1:0]     upd_x, upd_y;
  logic signed [COORD_WIDTH:0] upd_step_x, upd_step_y;
  mpt_pkg::upd_flags_t        upd_flags;

  mpt_cfg #(.COORD_WIDTH(COORD_WIDTH)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_x   (scr_w),
    .max_y   (scr_h)
  );

  mpt_update #(.COORD_WIDTH(COORD_WIDTH)) u_update (
    .byte0  (held0_r),
    .byte1  (held1_r),
    .byte2  (in_byte_r),
    .cur_x  (cursor_x_r),
    .cur_y  (cursor_y_r),
    .lim_x  (scr_w),
    .lim_y  (scr_h),
    .new_x  (upd_x),
    .new_y  (upd_y),
    .step_x (upd_step_x),
    .step_y (upd_step_y),
    .flags  (upd_flags)
  );

  // Process the registered item once the result register can take its output
  assign advance     = !out_valid_r || out_if.ready;
  assign proc        = in_valid_r && advance;
  assign finish      = proc && (in_cmd_r == mpt_pkg::CMD_BYTE) &&
                       (byte_idx_r == mpt_pkg::IDX_THIRD);
  assign in_if.ready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_if.ready) begin
      in_valid_nxt = in_if.valid;
    end
  end

  always_comb begin
    byte_idx_nxt = byte_idx_r;
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    if (proc) begin
      case (in_cmd_r)
        mpt_pkg::CMD_RECENTER: begin
          cursor_x_nxt = scr_w >> 1;
          cursor_y_nxt = scr_h >> 1;
        end
        mpt_pkg::CMD_BYTE: begin
          case (byte_idx_r)
            mpt_pkg::IDX_FIRST: begin
              // drop bytes that cannot start a packet
              if (in_byte_r[mpt_pkg::START_BIT]) begin
                byte_idx_nxt = mpt_pkg::IDX_SECOND;
              end
            end
            mpt_pkg::IDX_SECOND: byte_idx_nxt = mpt_pkg::IDX_THIRD;
            mpt_pkg::IDX_THIRD: begin
              byte_idx_nxt = mpt_pkg::IDX_FIRST;
              cursor_x_nxt = upd_x;
              cursor_y_nxt = upd_y;
            end
            default: byte_idx_nxt = mpt_pkg::IDX_FIRST;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      byte_idx_r  <= mpt_pkg::IDX_FIRST;
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      byte_idx_r  <= byte_idx_nxt;
      cursor_x_r  <= cursor_x_nxt;
      cursor_y_r  <= cursor_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      in_cmd_r  <= in_if.command;
      in_byte_r <= in_if.data_byte;
    end
    if (proc && (in_cmd_r == mpt_pkg::CMD_BYTE)) begin
      if (byte_idx_r == mpt_pkg::IDX_FIRST) begin
        held0_r <= in_byte_r;
      end
      if (byte_idx_r == mpt_pkg::IDX_SECOND) begin
        held1_r <= in_byte_r;
      end
    end
    if (finish) begin
      res_x_r      <= upd_x;
      res_y_r      <= upd_y;
      res_btn_r    <= held0_r[2:0];
      res_flags_r  <= upd_flags;
      res_step_x_r <= upd_step_x;
      res_step_y_r <= upd_step_y;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.pos_x   = res_x_r;
  assign out_if.pos_y   = res_y_r;
  assign out_if.buttons = res_btn_r;
  assign out_if.moved   = res_flags_r.moved;
  assign out_if.clipped = res_flags_r.clipped;
  assign out_if.step_x  = res_step_x_r;
  assign out_if.step_y  = res_step_y_r;

`ifndef ASSERT_OFF
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_idx_r != 2'd3)
    else $error("packet slot count out of range");

  a_recenter: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && (in_cmd_r == mpt_pkg::CMD_RECENTER)) |=>
      (cursor_x_r == ($past(scr_w) >> 1)) && (cursor_y_r == ($past(scr_h) >> 1)))
    else $error("recenter did not place pointer at half screen");

  a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(finish))
    else $error("result appeared without a completed packet");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |-> !finish)
    else $error("result overwritten while stalled");
`endif

endmodule

FILE: dv/tb_mouse_pointer_tracker.sv
`timescale 1ns / 1ps
// Self-checking testbench for mouse_pointer_tracker: drives mouse byte and recenter
// transfers, programs the screen size over APB and checks every pointer update.
// Depends on mpt_pkg, mpt_stream_if and the mouse_pointer_tracker RTL.
module tb_mouse_pointer_tracker;

  localparam int COORD_W     = 12;
  localparam int ADDR_W      = mpt_pkg::CFG_ADDR_WIDTH;
  localparam int DATA_W      = mpt_pkg::CFG_DATA_WIDTH;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic                command;
    logic [7:0]          data_byte;
  } mouse_xfer_t;

  typedef struct packed {
    logic [COORD_W-1:0]  pos_x;
    logic [COORD_W-1:0]  pos_y;
    logic [2:0]          buttons;
    logic                moved;
    logic                clipped;
    logic signed [COORD_W:0] step_x;
    logic signed [COORD_W:0] step_y;
  } pointer_update_t;

  logic clk = 1'b0;
  logic rst_n;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic              pready;

  mpt_in_if                        in_ch ();
  mpt_out_if #(.COORD_WIDTH(COORD_W)) out_ch ();

  mouse_pointer_tracker #(.COORD_WIDTH(COORD_W)) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Pointer tracking state of the predictor
  logic [COORD_W-1:0] scr_w, scr_h;
  logic [COORD_W-1:0] cur_x, cur_y;
  logic [1:0]         pkt_slot;
  logic [7:0]         pkt_bytes [2];

  mouse_xfer_t     byte_queue [$];
  pointer_update_t update_queue [$];
  mouse_xfer_t     stroke;
  pointer_update_t got_upd, exp_upd;

  int  send_idle_pct, recv_idle_pct;
  bit  in_taken;
  int  fail_count, cycle_count;
  int  packets_checked, recenters_seen, bytes_dropped, sizes_used;

  function automatic int clamp_coord(input int v, input int limit, inout bit clip);
    if (v < 0) begin
      clip = 1'b1;
      return 0;
    end
    if (v > limit) begin
      clip = 1'b1;
      return limit;
    end
    return v;
  endfunction

  // Advance the predictor by one accepted transfer; returns 1 when a packet completes.
  function automatic bit track_pointer(input logic cmd, input logic [7:0] b,
                                       output pointer_update_t upd);
    int dx, dy, ox, oy, nx, ny;
    bit clip;
    upd  = '0;
    clip = 1'b0;
    if (cmd == mpt_pkg::CMD_RECENTER) begin
      cur_x = scr_w >> 1;
      cur_y = scr_h >> 1;
      recenters_seen++;
      return 1'b0;
    end
    if (pkt_slot == mpt_pkg::IDX_FIRST && !b[mpt_pkg::START_BIT]) begin
      bytes_dropped++;
      return 1'b0;
    end
    if (pkt_slot != mpt_pkg::IDX_THIRD) begin
      pkt_bytes[pkt_slot[0]] = b;
      pkt_slot++;
      return 1'b0;
    end
    pkt_slot = mpt_pkg::IDX_FIRST;
    dx = int'(pkt_bytes[1]) - (pkt_bytes[0][mpt_pkg::X_SIGN_BIT] ? 256 : 0);
    // screen Y grows downward, mouse Y grows upward
    dy = (pkt_bytes[0][mpt_pkg::Y_SIGN_BIT] ? 256 : 0) - int'(b);
    if (dx * dx + dy * dy >= 2 * 2) begin
      dx = dx * 2;
      dy = dy * 2;
    end
    ox = int'(cur_x);
    oy = int'(cur_y);
    nx = clamp_coord(ox + dx, int'(scr_w), clip);
    ny = clamp_coord(oy + dy, int'(scr_h), clip);
    cur_x = COORD_W'(nx);
    cur_y = COORD_W'(ny);
    upd.pos_x   = cur_x;
    upd.pos_y   = cur_y;
    upd.buttons = pkt_bytes[0][2:0];
    upd.moved   = (dx != 0 || dy != 0);
    upd.clipped = clip;
    upd.step_x  = (COORD_W + 1)'(nx - ox);
    upd.step_y  = (COORD_W + 1)'(ny - oy);
    return 1'b1;
  endfunction

  // Input driver: hold the current transfer until it is taken, then advance.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      in_taken = 1'b0;
      if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        stroke = byte_queue.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.command   <= stroke.command;
        in_ch.data_byte <= stroke.data_byte;
      end else begin
        in_ch.valid     <= 1'b0;
        in_ch.command   <= 1'($urandom);
        in_ch.data_byte <= 8'($urandom);
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: predict on each input transfer, check each result transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        in_taken = 1'b1;
        if (track_pointer(in_ch.command, in_ch.data_byte, exp_upd))
          update_queue.push_back(exp_upd);
      end
      if (out_ch.valid && out_ch.ready) begin
        got_upd.pos_x   = out_ch.pos_x;
        got_upd.pos_y   = out_ch.pos_y;
        got_upd.buttons = out_ch.buttons;
        got_upd.moved   = out_ch.moved;
        got_upd.clipped = out_ch.clipped;
        got_upd.step_x  = out_ch.step_x;
        got_upd.step_y  = out_ch.step_y;
        if (update_queue.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected pos=(%0d,%0d) btn=%0d moved=%0b clip=%0b step=(%0d,%0d)",
                   $realtime, got_upd.pos_x, got_upd.pos_y, got_upd.buttons, got_upd.moved,
                   got_upd.clipped, got_upd.step_x, got_upd.step_y);
        end else begin
          exp_upd = update_queue.pop_front();
          packets_checked++;
          if (got_upd !== exp_upd) begin
            fail_count++;
            $display("%0t: expected pos=(%0d,%0d) btn=%0d moved=%0b clip=%0b step=(%0d,%0d)",
                     $realtime, exp_upd.pos_x, exp_upd.pos_y, exp_upd.buttons, exp_upd.moved,
                     exp_upd.clipped, exp_upd.step_x, exp_upd.step_y);
            $display("%0t: actual   pos=(%0d,%0d) btn=%0d moved=%0b clip=%0b step=(%0d,%0d)",
                     $realtime, got_upd.pos_x, got_upd.pos_y, got_upd.buttons, got_upd.moved,
                     got_upd.clipped, got_upd.step_x, got_upd.step_y);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d transfers pending and %0d results outstanding",
               $realtime, byte_queue.size(), update_queue.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic cfg_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Program both screen registers and read them back; upper data bits are don't-care.
  task automatic set_screen(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] h);
    logic [DATA_W-1:0] rd;
    cfg_access(1'b1, ADDR_W'(4 * mpt_pkg::REG_MAX_X), w, rd);
    cfg_access(1'b1, ADDR_W'(4 * mpt_pkg::REG_MAX_Y), h, rd);
    scr_w = w[COORD_W-1:0];
    scr_h = h[COORD_W-1:0];
    sizes_used++;
    cfg_access(1'b0, ADDR_W'(4 * mpt_pkg::REG_MAX_X), '0, rd);
    if (rd !== DATA_W'(scr_w)) begin
      fail_count++;
      $display("%0t: width readback expected %0d actual %0d", $realtime, scr_w, rd);
    end
    cfg_access(1'b0, ADDR_W'(4 * mpt_pkg::REG_MAX_Y), '0, rd);
    if (rd !== DATA_W'(scr_h)) begin
      fail_count++;
      $display("%0t: height readback expected %0d actual %0d", $realtime, scr_h, rd);
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    byte_queue.push_back('{command: mpt_pkg::CMD_BYTE, data_byte: b});
  endtask

  task automatic push_packet(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
    push_byte(b0);
    push_byte(b1);
    push_byte(b2);
  endtask

  task automatic push_recenter();
    byte_queue.push_back('{command: mpt_pkg::CMD_RECENTER, data_byte: 8'($urandom)});
  endtask

  // Mostly well-formed packets, half of them with tiny deltas around the doubling threshold.
  task automatic queue_random_traffic(input int count);
    int n, r, vx, vy;
    logic [7:0] b0, b1, b2;
    n = 0;
    while (n < count) begin
      r = $urandom_range(99);
      if (r < 7) begin
        push_recenter();
        n++;
      end else if (r < 17) begin
        push_byte(8'($urandom));
      end else begin
        b0 = 8'($urandom);
        b0[mpt_pkg::START_BIT] = 1'b1;
        if ($urandom_range(1)) begin
          vx = int'($urandom_range(4)) - 2;
          vy = int'($urandom_range(4)) - 2;
          b1 = 8'(vx);
          b2 = 8'(vy);
          b0[mpt_pkg::X_SIGN_BIT] = (vx < 0);
          b0[mpt_pkg::Y_SIGN_BIT] = (vy < 0);
        end else begin
          b1 = 8'($urandom);
          b2 = 8'($urandom);
        end
        push_packet(b0, b1, b2);
        n += 3;
      end
    end
  endtask

  task automatic wait_drained();
    while (byte_queue.size() != 0 || in_ch.valid || update_queue.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] h,
                           input int send_pct, input int recv_pct, input int count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    set_screen(w, h);
    queue_random_traffic(count);
    wait_drained();
  endtask

  initial begin
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.command   = mpt_pkg::CMD_BYTE;
    in_ch.data_byte = '0;
    out_ch.ready    = 1'b0;
    scr_w           = COORD_W'(640);
    scr_h           = COORD_W'(480);
    cur_x           = '0;
    cur_y           = '0;
    pkt_slot        = mpt_pkg::IDX_FIRST;
    pkt_bytes[0]    = '0;
    pkt_bytes[1]    = '0;
    send_idle_pct   = 10;
    recv_idle_pct   = 54;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset screen size
    push_byte(8'h00);                      // no start bit while idle: dropped
    push_recenter();
    push_packet(8'h08, 8'h01, 8'h00);      // below doubling threshold
    push_packet(8'hFF, 8'h00, 8'h00);      // all buttons, overflow bits, full negative X
    push_packet(8'h08, 8'hFF, 8'h80);      // largest positive X, large upward Y
    push_packet(8'h38, 8'h01, 8'hFF);      // both sign bits
    push_packet(8'h08, 8'h00, 8'h00);      // no movement
    push_byte(8'h09);
    push_recenter();                       // recenter inside an open packet
    push_byte(8'h02);
    push_byte(8'h02);
    push_packet(8'h28, 8'h01, 8'hFF);      // squared magnitude 2, not doubled
    push_packet(8'h08, 8'h02, 8'h00);      // squared magnitude 4, doubled
    wait_drained();

    run_phase(32'd4095, 32'd4095, 10, 54, 120);
    run_phase(32'd1, 32'd1, 10, 54, 100);  // shrink below the pointer
    run_phase(32'd0, 32'd4095, 54, 10, 100);
    run_phase({20'($urandom), 12'($urandom_range(1, 4095))},
              {20'($urandom), 12'($urandom_range(1, 4095))}, 54, 10, 120);
    run_phase(32'd37, 32'd2, 0, 0, 100);
    run_phase(32'd640, 32'd480, 0, 0, 130);

    $display("Checked %0d pointer updates over %0d screen sizes", packets_checked, sizes_used + 1);
    $display("Recenters %0d, dropped bytes %0d, failures %0d",
             recenters_seen, bytes_dropped, fail_count);
    if (fail_count == 0 && update_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
